// File: rtl/wfvd_pkg.sv
`default_nettype none

package wfvd_pkg;

  localparam int MAX_VARINT_BYTES_DEF = 10;
  localparam int LENGTH_BITS_DEF      = 32;

  // Result status codes.
  localparam logic [2:0] ST_VALUE = 3'd0;
  localparam logic [2:0] ST_BYTE  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_ERROR = 3'd4;

  // Wire types.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  // Declared kinds.
  localparam logic [3:0] K_INT32    = 4'd0;
  localparam logic [3:0] K_UINT32   = 4'd1;
  localparam logic [3:0] K_INT64    = 4'd2;
  localparam logic [3:0] K_UINT64   = 4'd3;
  localparam logic [3:0] K_SINT32   = 4'd4;
  localparam logic [3:0] K_SINT64   = 4'd5;
  localparam logic [3:0] K_FIXED32  = 4'd6;
  localparam logic [3:0] K_SFIXED32 = 4'd7;
  localparam logic [3:0] K_FIXED64  = 4'd8;
  localparam logic [3:0] K_SFIXED64 = 4'd9;
  localparam logic [3:0] K_BOOL     = 4'd10;
  localparam logic [3:0] K_FLOAT    = 4'd11;
  localparam logic [3:0] K_DOUBLE   = 4'd12;
  localparam logic [3:0] K_STRING   = 4'd13;

  localparam logic [7:0] CONT_BIT = 8'h80;

  typedef struct packed {
    logic       mode;
    logic [2:0] wire_kind;
    logic [3:0] declared_kind;
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [63:0] value;
    logic        field_done;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/wfvd_core.sv
`default_nettype none

module wfvd_core #(
  parameter int MAX_VARINT_BYTES = wfvd_pkg::MAX_VARINT_BYTES_DEF,
  parameter int LENGTH_BITS      = wfvd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire wfvd_pkg::item_t item,
  output wfvd_pkg::result_t    res
);

  localparam int IDX_W = $clog2(MAX_VARINT_BYTES + 1);
  localparam logic [63:0] LEN_MASK =
      (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VARINT,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             kind_r, kind_nxt;
  logic                   skip_r, skip_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic [63:0]            acc_v;
  logic [IDX_W-1:0]       idx_v;
  logic [LENGTH_BITS-1:0] rem_d;
  logic [6:0]             var_sh;
  logic [3:0]             want;
  logic                   want_ok;
  logic                   wire_ok;

  function automatic logic [63:0] sext32(input logic [63:0] v);
    sext32 = {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] varint_value(input logic [3:0] k, input logic [63:0] v);
    logic [31:0] z;
    z = (v[31:0] >> 1) ^ {32{v[0]}};
    case (k)
      wfvd_pkg::K_INT32:  varint_value = sext32(v);
      wfvd_pkg::K_UINT32: varint_value = {32'd0, v[31:0]};
      wfvd_pkg::K_SINT32: varint_value = {{32{z[31]}}, z};
      wfvd_pkg::K_SINT64: varint_value = (v >> 1) ^ {64{v[0]}};
      wfvd_pkg::K_BOOL:   varint_value = {63'd0, (v != 64'd0)};
      default:            varint_value = v;
    endcase
  endfunction

  always_comb begin
    want    = 4'd0;
    want_ok = 1'b1;
    case (item.declared_kind) inside
      [wfvd_pkg::K_INT32:wfvd_pkg::K_SINT64], wfvd_pkg::K_BOOL:
        want = {1'b0, wfvd_pkg::WT_VARINT};
      wfvd_pkg::K_FIXED32, wfvd_pkg::K_SFIXED32, wfvd_pkg::K_FLOAT:
        want = {1'b0, wfvd_pkg::WT_I32};
      wfvd_pkg::K_FIXED64, wfvd_pkg::K_SFIXED64, wfvd_pkg::K_DOUBLE:
        want = {1'b0, wfvd_pkg::WT_I64};
      wfvd_pkg::K_STRING:
        want = {1'b0, wfvd_pkg::WT_LEN};
      default:
        want_ok = 1'b0;
    endcase
    wire_ok = (item.wire_kind == wfvd_pkg::WT_VARINT) ||
              (item.wire_kind == wfvd_pkg::WT_I64) ||
              (item.wire_kind == wfvd_pkg::WT_LEN) ||
              (item.wire_kind == wfvd_pkg::WT_I32);
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    skip_nxt  = skip_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    res       = '0;
    var_sh    = 7'(32'(idx_r) * 7);
    acc_v     = acc_r;
    idx_v     = idx_r + IDX_W'(1);
    rem_d     = rem_r - LENGTH_BITS'(1);

    if (!item.mode) begin
      phase_nxt = PH_IDLE;
      kind_nxt  = item.declared_kind;
      skip_nxt  = 1'b0;
      acc_nxt   = '0;
      idx_nxt   = '0;
      rem_nxt   = '0;
      if (!want_ok || !wire_ok) begin
        res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
      end else if ({1'b0, item.wire_kind} != want &&
                   (item.declared_kind == wfvd_pkg::K_BOOL ||
                    item.declared_kind == wfvd_pkg::K_STRING)) begin
        res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
      end else begin
        skip_nxt = ({1'b0, item.wire_kind} != want);
        case (item.wire_kind)
          wfvd_pkg::WT_VARINT: phase_nxt = PH_VARINT;
          wfvd_pkg::WT_LEN:    phase_nxt = PH_LENGTH;
          wfvd_pkg::WT_I64: begin
            phase_nxt = PH_FIXED;
            rem_nxt   = LENGTH_BITS'(8);
          end
          default: begin
            phase_nxt = PH_FIXED;
            rem_nxt   = LENGTH_BITS'(4);
          end
        endcase
      end
    end else begin
      case (phase_r)
        PH_VARINT, PH_LENGTH: begin
          // Seven payload bits per byte, low group first; bits past 63 fall off.
          acc_v   = acc_r | ({57'd0, item.data_byte[6:0]} << var_sh);
          acc_nxt = acc_v;
          idx_nxt = idx_v;
          if ((item.data_byte & wfvd_pkg::CONT_BIT) != 8'd0) begin
            if (idx_v >= IDX_W'(MAX_VARINT_BYTES) || item.buffer_end) begin
              res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
            end
          end else if (phase_r == PH_VARINT) begin
            if (skip_r) begin
              res = '{1'b1, wfvd_pkg::ST_SKIP, 64'd0, 1'b1};
            end else begin
              res = '{1'b1, wfvd_pkg::ST_VALUE, varint_value(kind_r, acc_v), 1'b1};
            end
          end else if (acc_v > LEN_MASK) begin
            res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
          end else begin
            rem_nxt = acc_v[LENGTH_BITS-1:0];
            if (acc_v == 64'd0) begin
              res = '{1'b1, skip_r ? wfvd_pkg::ST_SKIP : wfvd_pkg::ST_EMPTY, 64'd0, 1'b1};
            end else if (item.buffer_end) begin
              res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_FIXED: begin
          acc_v   = acc_r | ({56'd0, item.data_byte} << {idx_r[2:0], 3'b000});
          acc_nxt = acc_v;
          idx_nxt = idx_v;
          rem_nxt = rem_d;
          if (rem_d == '0) begin
            if (skip_r) begin
              res = '{1'b1, wfvd_pkg::ST_SKIP, 64'd0, 1'b1};
            end else if (kind_r == wfvd_pkg::K_SFIXED32) begin
              res = '{1'b1, wfvd_pkg::ST_VALUE, sext32(acc_v), 1'b1};
            end else begin
              res = '{1'b1, wfvd_pkg::ST_VALUE, acc_v, 1'b1};
            end
          end else if (item.buffer_end) begin
            res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_d;
          if (rem_d == '0) begin
            if (skip_r) begin
              res = '{1'b1, wfvd_pkg::ST_SKIP, 64'd0, 1'b1};
            end else begin
              res = '{1'b1, wfvd_pkg::ST_BYTE, {56'd0, item.data_byte}, 1'b1};
            end
          end else if (item.buffer_end) begin
            res = '{1'b1, wfvd_pkg::ST_ERROR, 64'd0, 1'b1};
          end else if (!skip_r) begin
            res = '{1'b1, wfvd_pkg::ST_BYTE, {56'd0, item.data_byte}, 1'b0};
          end
        end
        default: begin
        end
      endcase
    end

    // The last result of a field always returns the decoder to idle.
    if (res.valid && res.field_done) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= '0;
      skip_r  <= 1'b0;
      acc_r   <= '0;
      idx_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      skip_r  <= skip_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wire_field_value_decoder.sv
// A word accepted at a clock edge is held in the input register; when the result register
// is free or draining, its result word, if any, is registered there and shown on out_tvalid.
// Throughput: one word per cycle while out_tready stays high; the decode
// state advances once per word in a single pass between the two registers.
// Reset (rst_n low at a clock edge) empties both registers and sets the field
// state to idle; it takes effect at that edge.
`default_nettype none

module wire_field_value_decoder #(
  parameter int MAX_VARINT_BYTES = wfvd_pkg::MAX_VARINT_BYTES_DEF,
  parameter int LENGTH_BITS      = wfvd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic [7:0]  in_tuser,   // mode [0], wire_kind [3:1], declared_kind [7:4]
  input  wire logic        in_tlast,   // buffer_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // value
  output logic [2:0]       out_tuser,  // status
  output logic             out_tlast   // field_done
);

  logic              in_valid_r;
  wfvd_pkg::item_t   in_item_r;
  logic              out_valid_r;
  wfvd_pkg::result_t out_res_r;
  wfvd_pkg::result_t res;
  logic              fire;
  logic              in_acc;

  // The held word moves on whenever the result register is free or draining.
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
    if (in_acc) begin
      in_item_r <= '{in_tuser[0], in_tuser[3:1], in_tuser[7:4], in_tdata, in_tlast};
    end
  end

  wfvd_core #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (fire),
    .item (in_item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (fire && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.field_done;

  a_zero_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == wfvd_pkg::ST_ERROR || out_tuser == wfvd_pkg::ST_SKIP ||
                   out_tuser == wfvd_pkg::ST_EMPTY) |-> out_tdata == 64'd0)
    else $error("error, skip or empty result carries a nonzero value");

  a_byte_width : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == wfvd_pkg::ST_BYTE |-> out_tdata[63:8] == 56'd0)
    else $error("payload byte result has upper value bits set");

  a_done_nonbyte : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != wfvd_pkg::ST_BYTE |-> out_tlast)
    else $error("non-payload result without field_done");

  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while the pipeline is stalled");

endmodule

`default_nettype wire

// File: verif/wire_field_value_decoder_tb.sv
`timescale 1ns / 100ps

module wire_field_value_decoder_tb;

  typedef enum logic [2:0] {
    PHASE_IDLE,
    PHASE_VARINT,
    PHASE_FIXED,
    PHASE_LENGTH,
    PHASE_PAYLOAD
  } decode_phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
    logic        done;
  } field_result_t;

  // Wire types and kinds that the package leaves unnamed.
  localparam logic [2:0] WIRE_SGROUP = 3'd3;
  localparam logic [2:0] WIRE_EGROUP = 3'd4;
  localparam logic [2:0] WIRE_RSVD6  = 3'd6;
  localparam logic [2:0] WIRE_RSVD7  = 3'd7;
  localparam logic [3:0] K_RSVD14    = 4'd14;
  localparam logic [3:0] K_RSVD15    = 4'd15;
  localparam logic [3:0] WIRE_NONE   = 4'd8;

  localparam int          VARINT_GROUPS = 10;
  localparam logic [63:0] LENGTH_MAX    = ~64'd0 >> (64 - wfvd_pkg::LENGTH_BITS_DEF);
  localparam int          GAP_PCT       = 35;
  localparam int          REPORT_LIMIT  = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;  // data_byte
  logic [7:0]  in_tuser   = 8'd0;  // mode [0], wire_kind [3:1], declared_kind [7:4]
  logic        in_tlast   = 1'b0;  // buffer_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;          // value
  logic [2:0]  out_tuser;          // status
  logic        out_tlast;          // field_done

  bit            steady      = 1'b0;
  int            mismatches  = 0;
  int            words_used  = 0;
  field_result_t pending_results[$];

  // Decoder state as the predictor sees it.
  decode_phase_t phase      = PHASE_IDLE;
  logic [3:0]    kind_held  = 4'd0;
  logic          skipping   = 1'b0;
  logic [63:0]   accum      = 64'd0;
  logic [3:0]    byte_index = 4'd0;
  logic [63:0]   bytes_left = 64'd0;

  wire_field_value_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("wire_field_value_decoder_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
  end

  function automatic logic [3:0] natural_wire(input logic [3:0] kind);
    if (kind <= wfvd_pkg::K_SINT64 || kind == wfvd_pkg::K_BOOL)
      return {1'b0, wfvd_pkg::WT_VARINT};
    if (kind == wfvd_pkg::K_FIXED32 || kind == wfvd_pkg::K_SFIXED32 ||
        kind == wfvd_pkg::K_FLOAT)
      return {1'b0, wfvd_pkg::WT_I32};
    if (kind == wfvd_pkg::K_FIXED64 || kind == wfvd_pkg::K_SFIXED64 ||
        kind == wfvd_pkg::K_DOUBLE)
      return {1'b0, wfvd_pkg::WT_I64};
    if (kind == wfvd_pkg::K_STRING) return {1'b0, wfvd_pkg::WT_LEN};
    return WIRE_NONE;
  endfunction

  function automatic bit known_wire(input logic [2:0] wire_kind);
    return wire_kind == wfvd_pkg::WT_VARINT || wire_kind == wfvd_pkg::WT_I64 ||
           wire_kind == wfvd_pkg::WT_LEN || wire_kind == wfvd_pkg::WT_I32;
  endfunction

  function automatic logic [63:0] sign_extend32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] varint_result(input logic [3:0] kind, input logic [63:0] v);
    case (kind)
      wfvd_pkg::K_INT32:  return sign_extend32(v);
      wfvd_pkg::K_UINT32: return {32'd0, v[31:0]};
      wfvd_pkg::K_SINT32: return sign_extend32({32'd0, (v[31:0] >> 1) ^ {32{v[0]}}});
      wfvd_pkg::K_SINT64: return (v >> 1) ^ {64{v[0]}};
      wfvd_pkg::K_BOOL:   return {63'd0, v != 64'd0};
      default:            return v;
    endcase
  endfunction

  function automatic void close_field(input logic [2:0] st, input logic [63:0] val,
                                      input logic done, output field_result_t res);
    res = '{status: st, value: val, done: done};
    if (done) phase = PHASE_IDLE;
  endfunction

  // Advances the predicted state by one word; returns 1 when a result is due.
  function automatic bit decode_word(input logic mode, input logic [2:0] wire_kind,
                                     input logic [3:0] kind, input logic [7:0] b,
                                     input logic last, output field_result_t res);
    logic [3:0] want;
    res = '0;
    if (!mode) begin
      want = natural_wire(kind);
      phase = PHASE_IDLE;
      kind_held = kind;
      skipping = 1'b0;
      if (want == WIRE_NONE || !known_wire(wire_kind)) begin
        close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
        return 1'b1;
      end
      if ({1'b0, wire_kind} != want) begin
        if (kind == wfvd_pkg::K_BOOL || kind == wfvd_pkg::K_STRING) begin
          close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
          return 1'b1;
        end
        skipping = 1'b1;
      end
      accum = 64'd0;
      byte_index = 4'd0;
      bytes_left = 64'd0;
      if (wire_kind == wfvd_pkg::WT_VARINT) begin
        phase = PHASE_VARINT;
      end else if (wire_kind == wfvd_pkg::WT_LEN) begin
        phase = PHASE_LENGTH;
      end else begin
        phase = PHASE_FIXED;
        bytes_left = (wire_kind == wfvd_pkg::WT_I64) ? 64'd8 : 64'd4;
      end
      return 1'b0;
    end
    case (phase)
      PHASE_VARINT, PHASE_LENGTH: begin
        if (byte_index < VARINT_GROUPS) accum |= {57'd0, b[6:0]} << (7 * byte_index);
        byte_index = byte_index + 4'd1;
        if (b[7]) begin
          if (byte_index >= wfvd_pkg::MAX_VARINT_BYTES_DEF || last) begin
            close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
            return 1'b1;
          end
          return 1'b0;
        end
        if (phase == PHASE_VARINT) begin
          if (skipping) close_field(wfvd_pkg::ST_SKIP, 64'd0, 1'b1, res);
          else close_field(wfvd_pkg::ST_VALUE, varint_result(kind_held, accum), 1'b1, res);
          return 1'b1;
        end
        if (accum > LENGTH_MAX) begin
          close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
          return 1'b1;
        end
        bytes_left = accum;
        if (bytes_left == 64'd0) begin
          close_field(skipping ? wfvd_pkg::ST_SKIP : wfvd_pkg::ST_EMPTY, 64'd0, 1'b1, res);
          return 1'b1;
        end
        // A nonzero length cannot be the end of the buffer.
        if (last) begin
          close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
          return 1'b1;
        end
        phase = PHASE_PAYLOAD;
        return 1'b0;
      end
      PHASE_FIXED: begin
        accum |= {56'd0, b} << (8 * byte_index[2:0]);
        byte_index = byte_index + 4'd1;
        if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
        if (bytes_left == 64'd0) begin
          if (skipping) close_field(wfvd_pkg::ST_SKIP, 64'd0, 1'b1, res);
          else if (kind_held == wfvd_pkg::K_SFIXED32)
            close_field(wfvd_pkg::ST_VALUE, sign_extend32(accum), 1'b1, res);
          else close_field(wfvd_pkg::ST_VALUE, accum, 1'b1, res);
          return 1'b1;
        end
        if (last) begin
          close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
          return 1'b1;
        end
        return 1'b0;
      end
      PHASE_PAYLOAD: begin
        if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
        if (bytes_left == 64'd0) begin
          close_field(skipping ? wfvd_pkg::ST_SKIP : wfvd_pkg::ST_BYTE,
                      skipping ? 64'd0 : {56'd0, b}, 1'b1, res);
          return 1'b1;
        end
        if (last) begin
          close_field(wfvd_pkg::ST_ERROR, 64'd0, 1'b1, res);
          return 1'b1;
        end
        if (skipping) return 1'b0;
        close_field(wfvd_pkg::ST_BYTE, {56'd0, b}, 1'b0, res);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    field_result_t want;
    field_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word: status %0d value %h done %0b",
                     out_tuser, out_tdata, out_tlast);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.status || out_tdata !== want.value ||
              out_tlast !== want.done) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result mismatch: status %0d (exp %0d) value %h (exp %h) done %0b (exp %0b)",
                       out_tuser, want.status, out_tdata, want.value, out_tlast, want.done);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser[0] || phase != PHASE_IDLE) words_used++;
        if (decode_word(in_tuser[0], in_tuser[3:1], in_tuser[7:4], in_tdata, in_tlast, got))
          pending_results.push_back(got);
      end
    end
  end

  task automatic send_word(input logic mode, input logic [2:0] wire_kind,
                           input logic [3:0] kind, input logic [7:0] b, input logic last);
    if (!steady) begin
      while ($urandom_range(0, 99) < GAP_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {kind, wire_kind, mode};
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Fields that a word does not use carry random values.
  task automatic send_begin(input logic [2:0] wire_kind, input logic [3:0] kind);
    send_word(1'b0, wire_kind, kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    send_word(1'b1, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), b, last);
  endtask

  function automatic int varint_len(input logic [63:0] v);
    int n;
    n = 1;
    while (n < VARINT_GROUPS && (v >> (7 * n)) != 64'd0) n++;
    return n;
  endfunction

  // Sends the first nsend bytes of an nbytes long encoding of v.
  task automatic send_varint(input logic [63:0] v, input int nbytes, input int nsend,
                             input int end_at);
    logic [63:0] grp;
    for (int i = 0; i < nsend; i++) begin
      grp = (v >> (7 * i)) & 64'h7F;
      send_byte({(i < nbytes - 1), grp[6:0]}, i == end_at);
    end
  endtask

  task automatic send_fixed(input logic [63:0] v, input int nsend, input int end_at);
    for (int i = 0; i < nsend; i++) send_byte(v[8 * i +: 8], i == end_at);
  endtask

  task automatic send_payload(input int nsend, input int end_at);
    for (int i = 0; i < nsend; i++) send_byte(8'($urandom_range(0, 255)), i == end_at);
  endtask

  task automatic varint_field(input logic [2:0] wire_kind, input logic [3:0] kind,
                              input logic [63:0] v);
    send_begin(wire_kind, kind);
    send_varint(v, varint_len(v), varint_len(v), -1);
  endtask

  task automatic fixed_field(input logic [2:0] wire_kind, input logic [3:0] kind,
                             input logic [63:0] v);
    send_begin(wire_kind, kind);
    send_fixed(v, (wire_kind == wfvd_pkg::WT_I64) ? 8 : 4, -1);
  endtask

  function automatic logic [2:0] random_valid_wire();
    case ($urandom_range(0, 3))
      0:       return wfvd_pkg::WT_VARINT;
      1:       return wfvd_pkg::WT_I64;
      2:       return wfvd_pkg::WT_LEN;
      default: return wfvd_pkg::WT_I32;
    endcase
  endfunction

  function automatic logic [63:0] random_varint_value();
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 127));
      1:       return 64'($urandom_range(0, 20000));
      2:       return {32'd0, $urandom()};
      3:       return {$urandom(), $urandom()};
      4:       return {32'hFFFF_FFFF, $urandom()};
      default: return $urandom_range(0, 1) ? 64'd0 : ~64'd0;
    endcase
  endfunction

  task automatic send_random_field();
    int          pick;
    int          total;
    int          nbytes;
    int          nsend;
    int          end_at;
    int          len_bytes;
    logic [3:0]  kind;
    logic [3:0]  want;
    logic [2:0]  wire_kind;
    logic [63:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return;
    end
    kind = 4'($urandom_range(wfvd_pkg::K_INT32, wfvd_pkg::K_STRING));
    want = natural_wire(kind);
    wire_kind = want[2:0];
    if (pick < 7) begin
      kind = 4'($urandom_range(0, 15));
      wire_kind = 3'($urandom_range(0, 7));
    end else if (pick < 19) begin
      while ({1'b0, wire_kind} == want) wire_kind = random_valid_wire();
    end
    send_begin(wire_kind, kind);
    v = random_varint_value();
    nbytes = 0;
    len_bytes = 0;
    case (wire_kind)
      wfvd_pkg::WT_VARINT: begin
        nbytes = varint_len(v);
        if ($urandom_range(0, 99) < 8) nbytes = $urandom_range(nbytes, VARINT_GROUPS);
        else if ($urandom_range(0, 99) < 3) nbytes = VARINT_GROUPS + 1;
        total = nbytes;
      end
      wfvd_pkg::WT_I64: total = 8;
      wfvd_pkg::WT_I32: total = 4;
      wfvd_pkg::WT_LEN: begin
        pick = $urandom_range(0, 99);
        if (pick < 70) v = 64'($urandom_range(0, 6));
        else if (pick < 95) v = 64'($urandom_range(7, 24));
        else v = {32'($urandom_range(1, 255)), $urandom()};
        len_bytes = varint_len(v);
        total = len_bytes + ((v > LENGTH_MAX) ? 0 : int'(v));
      end
      default: total = $urandom_range(0, 2);
    endcase
    nsend = total;
    // Now and then the field is cut off and the next begin abandons it.
    if (total > 1 && $urandom_range(0, 99) < 4) nsend = $urandom_range(1, total - 1);
    end_at = -1;
    pick = $urandom_range(0, 99);
    if (pick < 5 && total > 0) end_at = $urandom_range(0, total - 1);
    else if (pick < 25) end_at = total - 1;
    case (wire_kind)
      wfvd_pkg::WT_VARINT: send_varint(v, nbytes, nsend, end_at);
      wfvd_pkg::WT_LEN: begin
        send_varint(v, len_bytes, (nsend < len_bytes) ? nsend : len_bytes, end_at);
        if (nsend > len_bytes) send_payload(nsend - len_bytes, end_at - len_bytes);
      end
      wfvd_pkg::WT_I64, wfvd_pkg::WT_I32: send_fixed({$urandom(), $urandom()}, nsend, end_at);
      default: send_payload(nsend, end_at);
    endcase
  endtask

  task automatic test_varint_kinds();
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_INT32, ~64'd0);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_UINT32, 64'h1_2345_6789);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_INT64, 64'h7FFF_FFFF_FFFF_FFFF);
    // The buffer may end on the byte that completes the field.
    send_begin(wfvd_pkg::WT_VARINT, wfvd_pkg::K_UINT64);
    send_varint(~64'd0, 10, 10, 9);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_SINT32, 64'd1);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_SINT32, 64'hFFFF_FFFE);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_SINT64, ~64'd0);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_BOOL, 64'd0);
    send_begin(wfvd_pkg::WT_VARINT, wfvd_pkg::K_BOOL);
    send_varint(64'h100, 2, 2, -1);
  endtask

  task automatic test_fixed_kinds();
    fixed_field(wfvd_pkg::WT_I32, wfvd_pkg::K_FIXED32, 64'hFFFF_FFFF);
    fixed_field(wfvd_pkg::WT_I32, wfvd_pkg::K_SFIXED32, 64'h8000_0000);
    fixed_field(wfvd_pkg::WT_I64, wfvd_pkg::K_FIXED64, {$urandom(), $urandom()});
    fixed_field(wfvd_pkg::WT_I64, wfvd_pkg::K_SFIXED64, 64'h8000_0000_0000_0000);
    fixed_field(wfvd_pkg::WT_I32, wfvd_pkg::K_FLOAT, 64'h7FC0_0000);
    fixed_field(wfvd_pkg::WT_I64, wfvd_pkg::K_DOUBLE, 64'hFFF0_0000_0000_0001);
  endtask

  task automatic test_delimited();
    varint_field(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING, 64'd0);
    varint_field(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING, 64'd3);
    send_payload(3, -1);
    varint_field(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING, 64'd1);
    send_payload(1, 0);
    varint_field(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING, 64'd130);
    send_payload(130, -1);
    varint_field(wfvd_pkg::WT_LEN, wfvd_pkg::K_INT32, 64'd2);
    send_payload(2, -1);
  endtask

  task automatic test_malformed();
    send_begin(WIRE_SGROUP, wfvd_pkg::K_INT64);
    send_begin(WIRE_EGROUP, wfvd_pkg::K_UINT32);
    send_begin(WIRE_RSVD6, wfvd_pkg::K_FIXED32);
    send_begin(WIRE_RSVD7, wfvd_pkg::K_STRING);
    send_begin(wfvd_pkg::WT_VARINT, K_RSVD14);
    send_begin(wfvd_pkg::WT_I64, K_RSVD15);
    send_begin(wfvd_pkg::WT_I32, wfvd_pkg::K_BOOL);
    // Nothing is in progress, so these bytes are dropped.
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_begin(wfvd_pkg::WT_VARINT, wfvd_pkg::K_STRING);
    send_begin(wfvd_pkg::WT_VARINT, wfvd_pkg::K_UINT64);
    send_varint(~64'd0, VARINT_GROUPS + 1, VARINT_GROUPS, -1);
    send_begin(wfvd_pkg::WT_VARINT, wfvd_pkg::K_INT64);
    send_varint(64'h4000, 3, 3, 1);
    send_begin(wfvd_pkg::WT_I64, wfvd_pkg::K_FIXED64);
    send_fixed({$urandom(), $urandom()}, 8, 3);
    send_begin(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING);
    send_varint(64'd5, 1, 1, 0);
    send_begin(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING);
    send_varint(64'd4, 1, 1, -1);
    send_payload(4, 1);
    send_begin(wfvd_pkg::WT_LEN, wfvd_pkg::K_STRING);
    send_varint(64'h1_0000_0000, 5, 5, -1);
    send_begin(wfvd_pkg::WT_I64, wfvd_pkg::K_DOUBLE);
    send_fixed({$urandom(), $urandom()}, 3, -1);
    varint_field(wfvd_pkg::WT_VARINT, wfvd_pkg::K_FIXED32, 64'h1234);
    fixed_field(wfvd_pkg::WT_I64, wfvd_pkg::K_INT64, {$urandom(), $urandom()});
    fixed_field(wfvd_pkg::WT_I32, wfvd_pkg::K_SINT32, {$urandom(), $urandom()});
    varint_field(wfvd_pkg::WT_LEN, wfvd_pkg::K_FLOAT, 64'd0);
  endtask

  task automatic test_random_fields(input int words);
    int target;
    target = words_used + words;
    while (words_used < target) send_random_field();
  endtask

  task automatic test_steady_stream(input int words);
    steady = 1'b1;
    test_random_fields(words);
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_varint_kinds();
    test_fixed_kinds();
    test_delimited();
    test_malformed();
    test_random_fields(650);
    test_steady_stream(300);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("wire_field_value_decoder_tb: PASS");
    end else begin
      $display("wire_field_value_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
